### src/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
`default_nettype none

package uer_pkg;

  // Time base and range constants
  localparam int unsigned TICK_NS    = 1000;
  localparam int unsigned MAX_NS     = 40438871;
  localparam int unsigned MUL_NUM    = 106;
  localparam int unsigned MUL_DEN    = 617176;

  localparam int unsigned CNT_W      = 20;
  localparam int unsigned TRIG_W     = 10;
  localparam int unsigned DIST_W     = 13;
  localparam int unsigned REM_W      = 20;

  // Longest echo in ticks that is still in range: ticks*TICK_NS > MAX_NS
  // exactly when ticks > MAX_NS / TICK_NS.
  localparam logic [31:0] MAX_TICKS  = 32'(MAX_NS / TICK_NS);

  // Distance grows by STEP_Q mm and STEP_R / MUL_DEN mm per echo tick.
  localparam int unsigned STEP_K     = TICK_NS * MUL_NUM;
  localparam logic [DIST_W-1:0] STEP_Q = DIST_W'(STEP_K / MUL_DEN);
  localparam logic [REM_W:0]    STEP_R = (REM_W+1)'(STEP_K % MUL_DEN);
  localparam logic [REM_W:0]    DEN    = (REM_W+1)'(MUL_DEN);

  // Register indexes
  localparam logic [1:0] REG_TRIGGER = 2'd0;
  localparam logic [1:0] REG_RISE_TO = 2'd1;
  localparam logic [1:0] REG_FALL_TO = 2'd2;

  // Reset values
  localparam logic [TRIG_W-1:0] TRIGGER_RST = TRIG_W'(10);
  localparam logic [CNT_W-1:0]  RISE_TO_RST = CNT_W'(20000);
  localparam logic [CNT_W-1:0]  FALL_TO_RST = CNT_W'(50000);

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [TRIG_W-1:0] trigger_ticks;
    logic [CNT_W-1:0]  rise_timeout_ticks;
    logic [CNT_W-1:0]  fall_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              trig_out;
    logic              done_res;
    logic [1:0]        status;
    logic [DIST_W-1:0] distance_mm;
  } res_t;

endpackage

`default_nettype wire

### src/uer_regs.sv
// Configuration register file with an APB-style access port.
// Depends on uer_pkg for register indexes, widths and reset values.
`default_nettype none

module uer_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output uer_pkg::cfg_t     cfg_o
);
  import uer_pkg::*;

  logic [TRIG_W-1:0] trigger_q;
  logic [CNT_W-1:0]  rise_to_q;
  logic [CNT_W-1:0]  fall_to_q;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q <= TRIGGER_RST;
      rise_to_q <= RISE_TO_RST;
      fall_to_q <= FALL_TO_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TRIGGER: trigger_q <= pwdata[TRIG_W-1:0];
        REG_RISE_TO: rise_to_q <= pwdata[CNT_W-1:0];
        REG_FALL_TO: fall_to_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TRIGGER: prdata = {{(32-TRIG_W){1'b0}}, trigger_q};
      REG_RISE_TO: prdata = {{(32-CNT_W){1'b0}}, rise_to_q};
      REG_FALL_TO: prdata = {{(32-CNT_W){1'b0}}, fall_to_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.trigger_ticks      = trigger_q;
  assign cfg_o.rise_timeout_ticks = rise_to_q;
  assign cfg_o.fall_timeout_ticks = fall_to_q;

endmodule

`default_nettype wire

### src/uer_dist.sv
// Running distance accumulator: tracks echo ticks * TICK_NS * 106 / 617176
// as a quotient and remainder, one add and compare per tick. Uses uer_pkg.
`default_nettype none

module uer_dist (
  input  wire logic                       clk_i,
  input  wire logic                       clr_i,
  input  wire logic                       step_i,
  output logic [uer_pkg::DIST_W-1:0]      dist_next_o
);
  import uer_pkg::*;

  logic [DIST_W-1:0] dist_q, dist_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [REM_W:0]    rem_sum;
  logic              carry;

  always_comb begin
    rem_sum = {1'b0, rem_q} + STEP_R;
    carry   = (rem_sum >= DEN);
    rem_d   = carry ? REM_W'(rem_sum - DEN) : rem_sum[REM_W-1:0];
    dist_d  = dist_q + STEP_Q + DIST_W'(carry);
  end

  assign dist_next_o = dist_d;

  // Cleared on entry to the echo wait, so no reset needed
  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      dist_q <= '0;
      rem_q  <= '0;
    end else if (step_i) begin
      dist_q <= dist_d;
      rem_q  <= rem_d;
    end
  end

endmodule

`default_nettype wire

### src/uer_core.sv
// Measurement sequencer: trigger pulse, echo rise and fall waits, timeouts.
// Depends on uer_pkg and instantiates uer_dist.
`default_nettype none

module uer_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          start_i,
  input  wire logic          echo_i,
  input  wire uer_pkg::cfg_t cfg_i,
  output uer_pkg::res_t      res_o
);
  import uer_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_RISE = 2'd2;
  localparam logic [1:0] PH_FALL = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  count_inc;
  logic              last_echo_q;
  logic              rise_edge, fall_edge;
  logic              dist_clr, dist_step;
  logic [DIST_W-1:0] dist_next;

  uer_dist u_dist (
    .clk_i       (clk_i),
    .clr_i       (step_i & dist_clr),
    .step_i      (step_i & dist_step),
    .dist_next_o (dist_next)
  );

  assign count_inc = count_q + CNT_W'(1);
  assign rise_edge = echo_i & ~last_echo_q;
  assign fall_edge = ~echo_i & last_echo_q;

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    dist_clr  = 1'b0;
    dist_step = 1'b0;
    res_o     = '{trig_out: 1'b0, done_res: 1'b0, status: ST_OK, distance_mm: '0};
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d        = PH_TRIG;
          count_d        = CNT_W'(1);
          res_o.trig_out = 1'b1;
        end
      end
      PH_TRIG: begin
        if (count_q >= {{(CNT_W-TRIG_W){1'b0}}, cfg_i.trigger_ticks}) begin
          phase_d = PH_RISE;
          count_d = '0;
        end else begin
          count_d        = count_inc;
          res_o.trig_out = 1'b1;
        end
      end
      PH_RISE: begin
        if (rise_edge) begin
          phase_d  = PH_FALL;
          count_d  = '0;
          dist_clr = 1'b1;
        end else if (count_inc >= cfg_i.rise_timeout_ticks || count_inc == '0) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_TIMEOUT;
          phase_d        = PH_IDLE;
          count_d        = '0;
        end else begin
          count_d = count_inc;
        end
      end
      PH_FALL: begin
        dist_step = 1'b1;
        count_d   = count_inc;
        if (fall_edge) begin
          res_o.done_res = 1'b1;
          if ({{(32-CNT_W){1'b0}}, count_inc} > MAX_TICKS) begin
            res_o.status = ST_TOO_LONG;
          end else if (count_inc != '0) begin
            res_o.distance_mm = dist_next;
          end
          phase_d = PH_IDLE;
          count_d = '0;
        end else if (count_inc >= cfg_i.fall_timeout_ticks || count_inc == '0) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_TIMEOUT;
          phase_d        = PH_IDLE;
          count_d        = '0;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      last_echo_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      last_echo_q <= echo_i;
    end
  end

endmodule

`default_nettype wire

### src/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger, top level: input register, sequencer, result register.
// Depends on uer_pkg, uer_regs, uer_core (with uer_dist).
`default_nettype none

// Each input transaction is one tick of the time base, carrying a start request
// and the sampled echo level; each one yields exactly one result transaction
// with the trigger pin level and, on the tick a measurement ends, a done flag
// with status (ok, timeout, echo too long) and the distance in millimeters.
// Throughput is one transaction per clock cycle while out_stall_i is low; each
// passes the input register and the result register that sandwich the sequencer.
// The distance is kept as a running quotient and remainder while the echo is
// high, so the divide by 617176 costs one add and compare per tick. Write the
// configuration registers (trigger length at 0x0, rise timeout at 0x4, fall
// timeout at 0x8) only while no transaction is in flight. in_stall_o rises only
// when both internal registers are full and the output is stalled.
module ultrasonic_echo_ranger (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        start_req_i,
  input  wire logic        echo_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             trig_out_o,
  output logic             done_res_o,
  output logic [1:0]       status_o,
  output logic [12:0]      distance_mm_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import uer_pkg::*;

  cfg_t cfg;
  res_t res_d, res_q;

  logic in_valid_q;
  logic start_q;
  logic echo_q;
  logic out_valid_q;
  logic advance;
  logic in_take;

  uer_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move the held tick into the result register when that slot frees up
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  // Stall upstream only while the held tick cannot advance
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  uer_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .start_i (start_q),
    .echo_i  (echo_q),
    .cfg_i   (cfg),
    .res_o   (res_d)
  );

  // Input register: valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      start_q <= start_req_i;
      echo_q  <= echo_i;
    end
  end

  // Result register: valid bit; drop it once the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign trig_out_o    = res_q.trig_out;
  assign done_res_o    = res_q.done_res;
  assign status_o      = res_q.status;
  assign distance_mm_o = res_q.distance_mm;

`ifndef SYNTH
  // Trigger drive and measurement completion never share a tick
  a_trig_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(trig_out_o && done_res_o))
    else $error("trigger and done in the same result");

  // Idle ticks carry a clean status and distance
  a_not_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> (status_o == ST_OK && distance_mm_o == '0))
    else $error("status or distance set without done");

  // A failed measurement reports no distance
  a_fail_no_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (distance_mm_o == '0))
    else $error("distance reported with error status");

  // Upstream is held off only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");
`endif

endmodule

`default_nettype wire
